@@ rtl/slhc_pkg.sv @@
// ----------------------------------------------------------------------------
// slhc_pkg - shared types and constants of the straight line heading controller
// Register map, configuration group, queue entry and fixed-point constants.
// ----------------------------------------------------------------------------
package slhc_pkg;

	localparam int PADDR_W      = 4;
	localparam int PDATA_W      = 32;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam int HDG_FRAC     = 13;
	localparam int ROOT_STEPS   = 32;
	localparam int ROOT_CNT_W   = $clog2(ROOT_STEPS);

	localparam logic signed [26:0] HEADING_GAIN = 27'sd500;
	localparam logic signed [9:0]  SLOW_SPEED   = 10'sd70;
	// n / 20 for n < 256 as (n * 205) >> 12
	localparam logic [7:0]         RAMP_MUL     = 8'd205;
	localparam int                 RAMP_SHIFT   = 12;

	typedef enum logic [1:0] {
		REG_NOMINAL_SPEED   = 2'd0,
		REG_REVERSE         = 2'd1,
		REG_TARGET_DISTANCE = 2'd2,
		REG_TARGET_HEADING  = 2'd3
	} slhc_reg_idx_t;

	typedef struct packed {
		logic [7:0]         nominal_speed;
		logic               reverse;
		logic [30:0]        target_distance;
		logic signed [15:0] target_heading;
	} slhc_cfg_t;

	typedef struct packed {
		logic               start_req;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [16:0] head_err;
	} slhc_entry_t;

endpackage

@@ rtl/slhc_if.sv @@
// ----------------------------------------------------------------------------
// slhc_if - item channels of the straight line heading controller
// Odometry sample channel and motor command channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface slhc_sample_if;
	logic               valid;
	logic               ready;
	logic               start_req;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [15:0] heading;

	modport source (output valid, start_req, pos_x, pos_y, heading, input ready);
	modport sink   (input valid, start_req, pos_x, pos_y, heading, output ready);
endinterface

interface slhc_command_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] right_command;
	logic signed [15:0] left_command;
	logic               done_res;

	modport source (output valid, right_command, left_command, done_res, input ready);
	modport sink   (input valid, right_command, left_command, done_res, output ready);
endinterface

@@ rtl/straight_line_heading_controller_unit.sv @@
// ----------------------------------------------------------------------------
// straight_line_heading_controller_unit - straight line heading controller
// Drives a differential motor pair along a line from odometry items.
// ----------------------------------------------------------------------------
// Usage:
//   sample  : odometry items (start_req, pos_x, pos_y, heading), valid/ready.
//   command : one item per sample (right_command, left_command, done_res).
//   APB     : nominal_speed 0x0, reverse 0x4, target_distance 0x8,
//             target_heading 0xC; write only while no item is in flight.
// Path: 1 intake stage and the 2-entry queue, then the sequencer states
//   speed, square x, square y, sum, root, accumulate and emit.
// Overlap: the sequencer finishes one item, with the 32-step square root of
//   the step length, before it takes the next; intake and the 2-entry queue
//   take up to three further items meanwhile.
// Reset: all configuration, distance, speed and previous position clear
//   to zero; no command item is pending.
// Stall: a held command item keeps its value; the sequencer waits, the
//   queue fills, then sample.ready drops.
// ----------------------------------------------------------------------------
module straight_line_heading_controller_unit
	import slhc_pkg::*;
#(
	parameter int POSITION_FRACTION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	slhc_sample_if.sink        sample,
	slhc_command_if.source     command,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	slhc_cfg_t   cfg;
	logic        push_valid;
	logic        push_ready;
	slhc_entry_t push_entry;
	logic        pop_valid;
	logic        pop_ready;
	slhc_entry_t pop_entry;

	slhc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	slhc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample         (sample),
		.target_heading (cfg.target_heading),
		.push_valid     (push_valid),
		.push_ready     (push_ready),
		.push_entry     (push_entry)
	);

	slhc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	slhc_back #(
		.POSITION_FRACTION_BITS (POSITION_FRACTION_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.command   (command)
	);

endmodule

@@ rtl/slhc_cfg.sv @@
// ----------------------------------------------------------------------------
// slhc_cfg - configuration registers
// APB-style register file holding speed, direction, target distance and heading.
// ----------------------------------------------------------------------------
module slhc_cfg
	import slhc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output slhc_cfg_t          cfg
);

	slhc_cfg_t     cfg_q;
	slhc_reg_idx_t idx;

	assign idx    = slhc_reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_NOMINAL_SPEED:   cfg_q.nominal_speed   <= pwdata[7:0];
				REG_REVERSE:         cfg_q.reverse         <= pwdata[0];
				REG_TARGET_DISTANCE: cfg_q.target_distance <= pwdata[30:0];
				REG_TARGET_HEADING:  cfg_q.target_heading  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_NOMINAL_SPEED:   prdata = {24'd0, cfg_q.nominal_speed};
			REG_REVERSE:         prdata = {31'd0, cfg_q.reverse};
			REG_TARGET_DISTANCE: prdata = {1'b0, cfg_q.target_distance};
			REG_TARGET_HEADING:  prdata = 32'(cfg_q.target_heading);
			default:             prdata = '0;
		endcase
	end

endmodule

@@ rtl/slhc_front.sv @@
// ----------------------------------------------------------------------------
// slhc_front - sample intake
// Accepts odometry items, forms the heading error and hands entries to the queue.
// ----------------------------------------------------------------------------
module slhc_front
	import slhc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	slhc_sample_if.sink        sample,
	input  logic signed [15:0] target_heading,
	output logic               push_valid,
	input  logic               push_ready,
	output slhc_entry_t        push_entry
);

	logic        valid_s1;
	slhc_entry_t entry_s1;
	logic        take;

	assign sample.ready = !valid_s1 || push_ready;
	assign take         = sample.valid && sample.ready;
	assign push_valid   = valid_s1;
	assign push_entry   = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			entry_s1.start_req <= sample.start_req;
			entry_s1.pos_x     <= sample.pos_x;
			entry_s1.pos_y     <= sample.pos_y;
			entry_s1.head_err  <= 17'(sample.heading) - 17'(target_heading);
		end
	end

endmodule

@@ rtl/slhc_queue.sv @@
// ----------------------------------------------------------------------------
// slhc_queue - entry queue
// Short FIFO decoupling sample intake from the arithmetic sequencer.
// ----------------------------------------------------------------------------
module slhc_queue
	import slhc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push_valid,
	output logic        push_ready,
	input  slhc_entry_t push_entry,
	output logic        pop_valid,
	input  logic        pop_ready,
	output slhc_entry_t pop_entry
);

	slhc_entry_t       mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_entry  = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

@@ rtl/slhc_back.sv @@
// ----------------------------------------------------------------------------
// slhc_back - control sequencer
// Speed ramp, heading correction, step length by iterative square root,
// distance accumulation and the command output register.
// ----------------------------------------------------------------------------
module slhc_back
	import slhc_pkg::*;
#(
	parameter int POSITION_FRACTION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  slhc_cfg_t   cfg,
	input  logic        pop_valid,
	output logic        pop_ready,
	input  slhc_entry_t pop_entry,
	slhc_command_if.source command
);

	localparam logic signed [32:0] SLOW_ZONE =
		33'((((64'd1 << POSITION_FRACTION_BITS) + 64'd5) / 64'd10));

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_SPEED = 8'b0000_0010,
		ST_SQX   = 8'b0000_0100,
		ST_SQY   = 8'b0000_1000,
		ST_SUM   = 8'b0001_0000,
		ST_ROOT  = 8'b0010_0000,
		ST_ACCUM = 8'b0100_0000,
		ST_EMIT  = 8'b1000_0000
	} slhc_state_t;

	slhc_state_t            state_q;
	slhc_entry_t            ent_q;
	logic signed [31:0]     prev_x_q;
	logic signed [31:0]     prev_y_q;
	logic [31:0]            dist_q;
	logic signed [9:0]      speed_q;
	logic signed [9:0]      spd_q;
	logic [31:0]            adx_q;
	logic [31:0]            ady_q;
	logic [63:0]            sqx_q;
	logic [63:0]            sqy_q;
	logic [63:0]            rad_q;
	logic                   ovf_q;
	logic [33:0]            rem_q;
	logic [31:0]            root_q;
	logic [ROOT_CNT_W-1:0]  cnt_q;
	logic signed [15:0]     right_q;
	logic signed [15:0]     left_q;
	logic                   done_q;
	logic                   out_valid_q;
	logic signed [15:0]     out_right_q;
	logic signed [15:0]     out_left_q;
	logic                   out_done_q;

	logic signed [32:0] dx;
	logic signed [32:0] dy;
	logic [15:0]        ramp_prod;
	logic [9:0]         ramp_mag;
	logic signed [9:0]  ramp_step;
	logic [9:0]         spd_abs;
	logic signed [32:0] remaining;
	logic signed [9:0]  spd_new;
	logic [31:0]        mul_a;
	logic [63:0]        prod;
	logic signed [26:0] err;
	logic signed [27:0] spd_ext;
	logic [35:0]        rem_sh;
	logic [35:0]        trial;
	logic [31:0]        step_len;
	logic [32:0]        acc;
	logic [31:0]        new_dist;
	logic               finished;
	logic               out_free;

	function automatic logic signed [15:0] scale_cmd(input logic signed [27:0] v);
		logic signed [27:0] b;
		logic signed [27:0] q;
		b = v[27] ? v + 28'sd8191 : v;
		q = b >>> HDG_FRAC;
		if (q > 28'sd32767) begin
			return 16'sh7fff;
		end else if (q < -28'sd32768) begin
			return 16'sh8000;
		end
		return q[15:0];
	endfunction

	assign pop_ready = (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || command.ready;

	assign dx = 33'(ent_q.pos_x) - 33'(prev_x_q);
	assign dy = 33'(ent_q.pos_y) - 33'(prev_y_q);

	// speed ramp and slow zone
	always_comb begin
		ramp_prod = 16'(cfg.nominal_speed) * 16'(RAMP_MUL);
		ramp_mag  = 10'(ramp_prod[15:RAMP_SHIFT]);
		ramp_step = cfg.reverse ? -$signed(ramp_mag) : $signed(ramp_mag);
		spd_abs   = speed_q[9] ? 10'(-speed_q) : 10'(speed_q);
		remaining = $signed({2'b00, cfg.target_distance}) - $signed({1'b0, dist_q});
		spd_new   = speed_q;
		if (spd_abs < {2'b00, cfg.nominal_speed}) begin
			spd_new = speed_q + ramp_step;
		end
		if (remaining < SLOW_ZONE) begin
			spd_new = cfg.reverse ? -SLOW_SPEED : SLOW_SPEED;
		end
	end

	assign mul_a   = (state_q == ST_SQY) ? ady_q : adx_q;
	assign prod    = mul_a * mul_a;
	assign err     = 27'(ent_q.head_err) * HEADING_GAIN;
	assign spd_ext = 28'(spd_q) <<< HDG_FRAC;

	// one root bit per cycle
	assign rem_sh = {rem_q, rad_q[63:62]};
	assign trial  = {2'b00, root_q, 2'b01};

	assign step_len = ovf_q ? '1 : root_q;
	assign acc      = {1'b0, dist_q} + {1'b0, step_len};
	assign new_dist = acc[32] ? '1 : acc[31:0];
	assign finished = new_dist > {1'b0, cfg.target_distance};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			dist_q      <= '0;
			speed_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (command.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						if (pop_entry.start_req) begin
							dist_q   <= '0;
							speed_q  <= '0;
							prev_x_q <= pop_entry.pos_x;
							prev_y_q <= pop_entry.pos_y;
						end
						state_q <= ST_SPEED;
					end
				end
				ST_SPEED: state_q <= ST_SQX;
				ST_SQX:   state_q <= ST_SQY;
				ST_SQY:   state_q <= ST_SUM;
				ST_SUM: begin
					cnt_q   <= '0;
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ROOT_CNT_W'(ROOT_STEPS - 1)) begin
						state_q <= ST_ACCUM;
					end
				end
				ST_ACCUM: begin
					dist_q   <= new_dist;
					prev_x_q <= ent_q.pos_x;
					prev_y_q <= ent_q.pos_y;
					speed_q  <= finished ? '0 : spd_q;
					state_q  <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop_valid) begin
					ent_q <= pop_entry;
				end
			end
			ST_SPEED: begin
				adx_q <= dx[32] ? 32'(-dx) : dx[31:0];
				ady_q <= dy[32] ? 32'(-dy) : dy[31:0];
				spd_q <= spd_new;
			end
			ST_SQX: begin
				sqx_q   <= prod;
				right_q <= scale_cmd(spd_ext - 28'(err));
				left_q  <= scale_cmd(spd_ext + 28'(err));
			end
			ST_SQY: begin
				sqy_q <= prod;
			end
			ST_SUM: begin
				{ovf_q, rad_q} <= {1'b0, sqx_q} + {1'b0, sqy_q};
				rem_q          <= '0;
				root_q         <= '0;
			end
			ST_ROOT: begin
				rad_q <= {rad_q[61:0], 2'b00};
				if (rem_sh >= trial) begin
					rem_q  <= 34'(rem_sh - trial);
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					rem_q  <= rem_sh[33:0];
					root_q <= {root_q[30:0], 1'b0};
				end
			end
			ST_ACCUM: begin
				done_q <= finished;
				if (finished) begin
					right_q <= '0;
					left_q  <= '0;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					out_right_q <= right_q;
					out_left_q  <= left_q;
					out_done_q  <= done_q;
				end
			end
			default: ;
		endcase
	end

	assign command.valid         = out_valid_q;
	assign command.right_command = out_right_q;
	assign command.left_command  = out_left_q;
	assign command.done_res      = out_done_q;

endmodule

@@ rtl/slhc_checker.sv @@
// ----------------------------------------------------------------------------
// slhc_checker - port checks of the heading controller
// Watches the item channels for spurious items, capacity and output consistency.
// ----------------------------------------------------------------------------
module slhc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] right_command,
	input logic signed [15:0] left_command,
	input logic               done_res
);

	logic [3:0] pending_q;
	logic       in_take;
	logic       out_take;

	assign in_take  = in_valid && in_ready;
	assign out_take = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_take && !out_take) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_take && !in_take) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("command item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			$stable(right_command) && $stable(left_command) && $stable(done_res))
		else $error("command item changed while stalled");

	a_done_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> right_command == 16'sd0 && left_command == 16'sd0)
		else $error("done item with motors running");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 4'd0)
		else $error("command item without a sample");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 4'd5)
		else $error("more samples held than the pipeline can store");

endmodule

bind straight_line_heading_controller_unit slhc_checker u_slhc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (sample.valid),
	.in_ready      (sample.ready),
	.out_valid     (command.valid),
	.out_ready     (command.ready),
	.right_command (command.right_command),
	.left_command  (command.left_command),
	.done_res      (command.done_res)
);
